// File: src/ncmq_pkg.sv
// Shared constants, types and helpers for the nearest-cost minimum query unit.
// No dependencies; used by every other file in src.
package ncmq_pkg;

	localparam int CFG_W             = 11;
	localparam int POS_W             = 10;
	localparam int PRICE_W           = 30;
	localparam int COST_W            = 31;
	localparam int MAX_POSITIONS_DEF = 1024;

	localparam logic [COST_W-1:0] EMPTY_COST = {COST_W{1'b1}};

	localparam logic FUNC_SET   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic              done;
		logic [COST_W-1:0] min_cost;
	} walk_status_t;

	function automatic logic [COST_W-1:0] cost_min(input logic [COST_W-1:0] a,
		input logic [COST_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

// File: src/nearest_cost_min_query_unit.sv
// Nearest-cost minimum query unit: two min-trees in synchronous memories.
// Depends on ncmq_pkg, ncmq_tree_mem and ncmq_range_walk.
//
// A set beat writes price+position and price+mirrored position into two
// min-trees and walks leaf to root, one tree level per cycle through a
// read-sibling / write-parent loop. A query beat runs two range walkers in
// parallel, one level per cycle with two read ports per tree, then combines
// both minima. One beat is in flight at a time; a finished result waits in
// the output register while the next beat is taken. After reset and after
// every positions_in_use write, a clearing pass empties both trees; in_ready
// is low during it.
module nearest_cost_min_query_unit #(
	parameter int MaxPositions = ncmq_pkg::MAX_POSITIONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ncmq_pkg::CFG_W-1:0]     cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic [ncmq_pkg::POS_W-1:0]     position,
	input  logic [ncmq_pkg::PRICE_W-1:0]   price,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ncmq_pkg::COST_W-1:0]    least_cost
);

	localparam int Depth = 2 * MaxPositions;
	localparam int AddrW = $clog2(Depth);
	localparam int UsedW = ($clog2(MaxPositions + 1) > ncmq_pkg::CFG_W) ?
		$clog2(MaxPositions + 1) : ncmq_pkg::CFG_W;
	localparam int CW    = ncmq_pkg::COST_W;

	localparam logic [AddrW-1:0] ClrLast = AddrW'(Depth - 1);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SET   = 5'b00100,
		ST_QRY   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [AddrW-1:0]       clr_idx_q, i_q;
	logic [UsedW-1:0]       used_q, cfg_used, last, pos_ext, pos_q_ext;
	logic                   first_q, oor_q, out_valid_q, accept, in_range, out_load;
	logic [CW-1:0]          va_q, vb_q, least_cost_q;
	logic [ncmq_pkg::POS_W-1:0] pos_q;

	logic                   mem_we, walk_start;
	logic [AddrW-1:0]       waddr, a_raddr0, b_raddr0;
	logic [AddrW-1:0]       wa_rd0, wa_rd1, wb_rd0, wb_rd1;
	logic [CW-1:0]          wr_a, wr_b, a_rd0, a_rd1, b_rd0, b_rd1;
	logic [CW-1:0]          ca, cb, qres;
	ncmq_pkg::walk_status_t stat_a, stat_b;

	assign in_ready   = (state_q == ST_IDLE) && !cfg_wr_en;
	assign accept     = in_valid && in_ready;
	assign last       = used_q - UsedW'(1);
	assign pos_ext    = UsedW'(position);
	assign pos_q_ext  = UsedW'(pos_q);
	assign in_range   = pos_ext < used_q;
	assign walk_start = accept && (func == ncmq_pkg::FUNC_QUERY) && in_range;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		cfg_used = UsedW'(cfg_wr_data);
		if (cfg_wr_data == '0) begin
			cfg_used = UsedW'(1);
		end
		if (cfg_used > UsedW'(MaxPositions)) begin
			cfg_used = UsedW'(MaxPositions);
		end
	end

	// tree write path: clear sweep or leaf-to-root update
	always_comb begin
		mem_we = 1'b0;
		waddr  = i_q;
		wr_a   = first_q ? va_q : ncmq_pkg::cost_min(va_q, a_rd0);
		wr_b   = first_q ? vb_q : ncmq_pkg::cost_min(vb_q, b_rd0);
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				waddr  = clr_idx_q;
				wr_a   = ncmq_pkg::EMPTY_COST;
				wr_b   = ncmq_pkg::EMPTY_COST;
			end
			ST_SET: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign a_raddr0 = (state_q == ST_SET) ? (i_q ^ AddrW'(1)) : wa_rd0;
	assign b_raddr0 = (state_q == ST_SET) ? (i_q ^ AddrW'(1)) : wb_rd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			used_q      <= UsedW'(MaxPositions);
			first_q     <= 1'b0;
			oor_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				used_q    <= cfg_used;
				state_q   <= ST_CLEAR;
				clr_idx_q <= '0;
			end else begin
				case (state_q)
					ST_CLEAR: begin
						clr_idx_q <= clr_idx_q + AddrW'(1);
						if (clr_idx_q == ClrLast) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (accept) begin
							if (func == ncmq_pkg::FUNC_SET) begin
								if (in_range) begin
									state_q <= ST_SET;
									first_q <= 1'b1;
								end
							end else begin
								oor_q   <= !in_range;
								state_q <= in_range ? ST_QRY : ST_DONE;
							end
						end
					end
					ST_SET: begin
						first_q <= 1'b0;
						if (i_q == AddrW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_QRY: begin
						if (stat_a.done && stat_b.done) begin
							state_q <= ST_DONE;
						end
					end
					ST_DONE: begin
						if (out_load) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			i_q   <= AddrW'(MaxPositions) + AddrW'(position);
			va_q  <= CW'(price) + CW'(position);
			vb_q  <= CW'(price) + CW'(last - pos_ext);
			pos_q <= position;
		end else if (state_q == ST_SET) begin
			i_q  <= i_q >> 1;
			va_q <= wr_a;
			vb_q <= wr_b;
		end
		if (out_load) begin
			least_cost_q <= qres;
		end
	end

	always_comb begin
		ca = (stat_a.min_cost == ncmq_pkg::EMPTY_COST) ? ncmq_pkg::EMPTY_COST :
			stat_a.min_cost - CW'(pos_q);
		cb = (stat_b.min_cost == ncmq_pkg::EMPTY_COST) ? ncmq_pkg::EMPTY_COST :
			stat_b.min_cost - CW'(last - pos_q_ext);
		qres = oor_q ? ncmq_pkg::EMPTY_COST : ncmq_pkg::cost_min(ca, cb);
	end

	assign out_valid  = out_valid_q;
	assign least_cost = least_cost_q;

	ncmq_tree_mem #(
		.Depth (Depth),
		.AddrW (AddrW)
	) u_mem_a (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (waddr),
		.wdata  (wr_a),
		.raddr0 (a_raddr0),
		.raddr1 (wa_rd1),
		.rdata0 (a_rd0),
		.rdata1 (a_rd1)
	);

	ncmq_tree_mem #(
		.Depth (Depth),
		.AddrW (AddrW)
	) u_mem_b (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (waddr),
		.wdata  (wr_b),
		.raddr0 (b_raddr0),
		.raddr1 (wb_rd1),
		.rdata0 (b_rd0),
		.rdata1 (b_rd1)
	);

	// plus-index tree: range [pos, last]
	ncmq_range_walk #(
		.MaxPositions (MaxPositions),
		.AddrW        (AddrW),
		.UsedW        (UsedW)
	) u_walk_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (walk_start),
		.lo       (pos_ext),
		.hi       (last),
		.rd0_addr (wa_rd0),
		.rd1_addr (wa_rd1),
		.rd0_data (a_rd0),
		.rd1_data (a_rd1),
		.status   (stat_a)
	);

	// plus-mirror tree: range [0, pos]
	ncmq_range_walk #(
		.MaxPositions (MaxPositions),
		.AddrW        (AddrW),
		.UsedW        (UsedW)
	) u_walk_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (walk_start),
		.lo       ('0),
		.hi       (pos_ext),
		.rd0_addr (wb_rd0),
		.rd1_addr (wb_rd1),
		.rd0_data (b_rd0),
		.rd1_data (b_rd1),
		.status   (stat_b)
	);

endmodule

// File: src/ncmq_tree_mem.sv
// One min-tree store: one write port, two read ports with registered read data.
// Depends on ncmq_pkg for the entry width.
module ncmq_tree_mem #(
	parameter int Depth = 2 * ncmq_pkg::MAX_POSITIONS_DEF,
	parameter int AddrW = $clog2(2 * ncmq_pkg::MAX_POSITIONS_DEF)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AddrW-1:0]              waddr,
	input  logic [ncmq_pkg::COST_W-1:0]   wdata,
	input  logic [AddrW-1:0]              raddr0,
	input  logic [AddrW-1:0]              raddr1,
	output logic [ncmq_pkg::COST_W-1:0]   rdata0,
	output logic [ncmq_pkg::COST_W-1:0]   rdata1
);

	logic [ncmq_pkg::COST_W-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

// File: src/ncmq_range_walk.sv
// Range-minimum walker: steps one tree level per cycle, issuing up to two reads,
// and folds the returned entries into a running minimum. Depends on ncmq_pkg.
module ncmq_range_walk #(
	parameter int MaxPositions = ncmq_pkg::MAX_POSITIONS_DEF,
	parameter int AddrW        = $clog2(2 * ncmq_pkg::MAX_POSITIONS_DEF),
	parameter int UsedW        = ncmq_pkg::CFG_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [UsedW-1:0]              lo,
	input  logic [UsedW-1:0]              hi,
	output logic [AddrW-1:0]              rd0_addr,
	output logic [AddrW-1:0]              rd1_addr,
	input  logic [ncmq_pkg::COST_W-1:0]   rd0_data,
	input  logic [ncmq_pkg::COST_W-1:0]   rd1_data,
	output ncmq_pkg::walk_status_t        status
);

	localparam int RW = AddrW + 1;

	logic [RW-1:0]               l_q, r_q, r_dec;
	logic                        act_q, done_q, use0_s1, use1_s1, step;
	logic [ncmq_pkg::COST_W-1:0] m_q, d0_sel, d1_sel;

	assign r_dec    = r_q - RW'(1);
	assign rd0_addr = l_q[AddrW-1:0];
	assign rd1_addr = r_dec[AddrW-1:0];
	assign step     = act_q && (l_q < r_q);

	assign d0_sel = use0_s1 ? rd0_data : ncmq_pkg::EMPTY_COST;
	assign d1_sel = use1_s1 ? rd1_data : ncmq_pkg::EMPTY_COST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			done_q  <= 1'b0;
			use0_s1 <= 1'b0;
			use1_s1 <= 1'b0;
		end else if (start) begin
			act_q   <= 1'b1;
			done_q  <= 1'b0;
			use0_s1 <= 1'b0;
			use1_s1 <= 1'b0;
		end else begin
			use0_s1 <= step && l_q[0];
			use1_s1 <= step && r_q[0];
			if (act_q && !step) begin
				act_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			l_q <= RW'(MaxPositions) + RW'(lo);
			r_q <= RW'(MaxPositions) + RW'(hi) + RW'(1);
			m_q <= ncmq_pkg::EMPTY_COST;
		end else begin
			if (step) begin
				l_q <= (l_q + RW'(l_q[0])) >> 1;
				r_q <= (r_q - RW'(r_q[0])) >> 1;
			end
			m_q <= ncmq_pkg::cost_min(m_q, ncmq_pkg::cost_min(d0_sel, d1_sel));
		end
	end

	assign status.done     = done_q;
	assign status.min_cost = m_q;

endmodule

// File: bench/testbench.sv
// Self-checking bench for nearest_cost_min_query_unit: directed and random set/query beats.
// Keeps a price table per position and predicts each least cost.
// Depends on ncmq_pkg and the unit's RTL in src.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CFG_W             = ncmq_pkg::CFG_W;
	localparam int POS_W             = ncmq_pkg::POS_W;
	localparam int PRICE_W           = ncmq_pkg::PRICE_W;
	localparam int COST_W            = ncmq_pkg::COST_W;
	localparam int MAX_POSITIONS_DEF = ncmq_pkg::MAX_POSITIONS_DEF;

	localparam logic [COST_W-1:0] EMPTY_COST = ncmq_pkg::EMPTY_COST;
	localparam logic FUNC_SET   = ncmq_pkg::FUNC_SET;
	localparam logic FUNC_QUERY = ncmq_pkg::FUNC_QUERY;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int SET_SETTLE   = 30;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int TAIL_CYCLES  = 40;

	typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]     cfg_wr_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 func = FUNC_SET;
	logic [POS_W-1:0]     position = '0;
	logic [PRICE_W-1:0]   price = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [COST_W-1:0]    least_cost;

	// predictor state
	logic [PRICE_W-1:0]   price_book [MAX_POSITIONS_DEF];
	bit                   price_known [MAX_POSITIONS_DEF];
	int                   used_count = MAX_POSITIONS_DEF;
	logic [COST_W-1:0]    pending_costs [$];

	int unsigned          cycle_count = 0;
	int                   fail_count = 0;

	// receiver stall control
	bit                   hold_ask = 1'b0;
	bit                   hold_seen = 1'b0;
	int                   hold_left = 0;
	rx_mode_t             rx_mode = RX_FREE;
	int                   rx_mode_left = 0;
	int                   rx_phase = 0;

	nearest_cost_min_query_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.position   (position),
		.price      (price),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.least_cost (least_cost)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic void forget_prices();
		int j;
		for (j = 0; j < MAX_POSITIONS_DEF; j++)
			price_known[j] = 1'b0;
	endfunction

	function automatic void apply_used(input logic [CFG_W-1:0] v);
		int n;
		n = int'(v);
		if (n == 0)
			n = 1;
		if (n > MAX_POSITIONS_DEF)
			n = MAX_POSITIONS_DEF;
		used_count = n;
		forget_prices();
	endfunction

	function automatic void record_price(input logic [POS_W-1:0] p,
		input logic [PRICE_W-1:0] pr);
		if (int'(p) < used_count) begin
			price_book[p] = pr;
			price_known[p] = 1'b1;
		end
	endfunction

	// least price(j) + |j - p| over known positions
	function automatic logic [COST_W-1:0] nearest_cost(input logic [POS_W-1:0] p);
		logic [COST_W-1:0] best;
		logic [COST_W-1:0] cand;
		int j;
		int gap;
		best = EMPTY_COST;
		if (int'(p) >= used_count)
			return EMPTY_COST;
		for (j = 0; j < used_count; j++) begin
			if (price_known[j]) begin
				gap = (j > int'(p)) ? j - int'(p) : int'(p) - j;
				cand = COST_W'(price_book[j]) + COST_W'(gap);
				if (cand < best)
					best = cand;
			end
		end
		return best;
	endfunction

	always @(posedge clk) begin
		if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 2));
				rx_mode_left <= $urandom_range(50, 300);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			rx_phase <= rx_phase + 1;
			case (rx_mode)
				RX_FREE: out_ready <= 1'b1;
				RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
				default: out_ready <= ((rx_phase % 7) < 4);
			endcase
		end
	end

	always @(posedge clk) begin
		logic [COST_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_costs.size() == 0) begin
				$error("least_cost: no query pending, got %0h", least_cost);
				fail_count++;
			end else begin
				want = pending_costs.pop_front();
				if (least_cost !== want) begin
					$error("least_cost: expected %0h, got %0h", want, least_cost);
					fail_count++;
				end
			end
		end
	end

	// one beat; valid stays high afterwards so bursts run back to back
	task automatic send_beat(input logic f, input logic [POS_W-1:0] p,
		input logic [PRICE_W-1:0] pr);
		in_valid <= 1'b1;
		func <= f;
		position <= p;
		price <= pr;
		do @(posedge clk); while (!in_ready);
		if (f == FUNC_QUERY)
			pending_costs.push_back(nearest_cost(p));
		else
			record_price(p, pr);
	endtask

	task automatic rest(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_costs.size() != 0) @(posedge clk);
		repeat (SET_SETTLE) @(posedge clk);
	endtask

	task automatic write_used(input logic [CFG_W-1:0] v);
		settle_idle();
		while (!in_ready) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		apply_used(v);
	endtask

	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 7);
		if (r < 6)
			return POS_W'($urandom_range(0, used_count - 1));
		else if (r == 6)
			return POS_W'($urandom);
		else
			return POS_W'(($urandom_range(0, 1) != 0) ? used_count - 1 : used_count);
	endfunction

	function automatic logic [PRICE_W-1:0] pick_price();
		int r;
		r = $urandom_range(0, 15);
		if (r < 8)
			return PRICE_W'($urandom_range(0, 64));
		else if (r < 12)
			return PRICE_W'($urandom_range(0, 4000));
		else if (r < 15)
			return PRICE_W'($urandom);
		else
			return {PRICE_W{1'b1}};
	endfunction

	task automatic random_run(input int n_items, input int set_pct);
		int burst_left;
		int k;
		logic f;
		burst_left = 0;
		for (k = 0; k < n_items; k++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				if ($urandom_range(0, 3) != 0)
					rest($urandom_range(1, 8));
			end
			burst_left--;
			f = ($urandom_range(0, 99) < set_pct) ? FUNC_SET : FUNC_QUERY;
			send_beat(f, pick_position(), pick_price());
		end
	endtask

	task automatic test_empty_and_extremes();
		send_beat(FUNC_QUERY, 10'd0, '0);
		send_beat(FUNC_QUERY, 10'd1023, {PRICE_W{1'b1}});
		send_beat(FUNC_SET, 10'd1023, {PRICE_W{1'b1}});
		send_beat(FUNC_QUERY, 10'd0, '0);
		send_beat(FUNC_QUERY, 10'd1023, '0);
		send_beat(FUNC_SET, 10'd0, '0);
		send_beat(FUNC_QUERY, 10'd512, '0);
		send_beat(FUNC_SET, 10'd512, 30'h2AAAAAAA);
		send_beat(FUNC_QUERY, 10'd511, 30'h15555555);
		send_beat(FUNC_QUERY, 10'd1023, '0);
	endtask

	task automatic test_used_limits();
		write_used(11'd0);
		send_beat(FUNC_SET, 10'd0, 30'd5);
		send_beat(FUNC_SET, 10'd1, 30'd0);
		send_beat(FUNC_QUERY, 10'd0, '0);
		send_beat(FUNC_QUERY, 10'd1, '0);
		send_beat(FUNC_QUERY, 10'd1023, '0);
		write_used(11'h7FF);
		send_beat(FUNC_SET, 10'd1023, 30'd1);
		send_beat(FUNC_QUERY, 10'd0, '0);
		write_used(11'd1025);
		send_beat(FUNC_QUERY, 10'd1023, '0);
		write_used(11'd2);
		send_beat(FUNC_SET, 10'd1, 30'd3);
		send_beat(FUNC_QUERY, 10'd0, '0);
		send_beat(FUNC_SET, 10'd0, 30'd100);
		send_beat(FUNC_QUERY, 10'd1, '0);
	endtask

	task automatic test_write_forgets_prices();
		write_used(11'd40);
		send_beat(FUNC_SET, 10'd7, 30'd9);
		send_beat(FUNC_SET, 10'd39, 30'd2);
		write_used(11'd40);
		send_beat(FUNC_QUERY, 10'd20, '0);
	endtask

	task automatic test_random_phases();
		int sizes [8];
		int k;
		sizes = '{1024, 1, 2, 7, 64, 1023, 300, 0};
		sizes[7] = $urandom_range(1, 1024);
		for (k = 0; k < 8; k++) begin
			write_used(CFG_W'(sizes[k]));
			random_run(90, 45);
		end
	endtask

	// receiver holds off while queries keep coming, so the input side backs up
	task automatic test_output_backpressure();
		int k;
		write_used(11'd16);
		for (k = 0; k < 6; k++)
			send_beat(FUNC_SET, POS_W'($urandom_range(0, 15)), pick_price());
		hold_ask <= ~hold_ask;
		for (k = 0; k < 40; k++)
			send_beat(FUNC_QUERY, POS_W'($urandom_range(0, 17)), pick_price());
		settle_idle();
	endtask

	task automatic test_drain_pause();
		write_used(11'd128);
		random_run(30, 50);
		settle_idle();
		random_run(30, 40);
	endtask

	initial begin
		int waited;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		forget_prices();
		test_empty_and_extremes();
		test_used_limits();
		test_write_forgets_prices();
		test_random_phases();
		test_output_backpressure();
		test_drain_pause();
		write_used(11'd1024);
		random_run(20, 50);
		in_valid <= 1'b0;
		for (waited = 0; pending_costs.size() != 0 && waited < DRAIN_LIMIT; waited++)
			@(posedge clk);
		if (pending_costs.size() != 0) begin
			$error("least_cost: %0d expected results never came", pending_costs.size());
			fail_count++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// File: nearest_cost_min_query_unit.f
src/ncmq_pkg.sv
src/ncmq_tree_mem.sv
src/ncmq_range_walk.sv
src/nearest_cost_min_query_unit.sv
bench/testbench.sv
